// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SETS_DEF     = 64;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDRESS_BITS_DEF = 32;

    // Fixed field widths.
    localparam int TAG_W      = 32;
    localparam int AGE_W      = 32;
    localparam int TOTAL_W    = 32;
    localparam int BB_W       = 13;
    localparam int SCFG_W     = 7;
    localparam int WCFG_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY      = 4'd0,
        REG_BLOCK_BYTES = 4'd1,
        REG_SET_COUNT   = 4'd2,
        REG_WAYS        = 4'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_IGNORE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    // One cache line as kept in the line memory.
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } t_line;

    // Control from the sequencer to a replacement unit.
    typedef struct packed {
        logic rd;         // read the row at the read set
        logic lookup_wr;  // write back the looked-up row
        logic age_wr;     // write back the aged row
    } t_unit_ctl;

endpackage

// ===== rtl/sacl_ifs.sv =====
interface sacl_in_if #(
    parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [ADDRESS_BITS-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface sacl_out_if;
    import sacl_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         outcome;
    logic               is_last;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;

    modport source (output valid, output outcome, output is_last, output total_hits,
                    output total_misses, output total_evictions, input ready);
    modport sink   (input valid, input outcome, input is_last, input total_hits,
                    input total_misses, input total_evictions, output ready);
endinterface

interface sacl_cfg_if;
    import sacl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sacl_div.sv =====
module sacl_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[NUM_W-2:0], fits};
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

// ===== rtl/sacl_lru.sv =====
module sacl_lru #(
    parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
    parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sacl_pkg::t_unit_ctl        i_ctl,
    input  logic [SET_W-1:0]           i_rd_set,
    input  logic [SET_W-1:0]           i_wr_set,
    input  logic [sacl_pkg::TAG_W-1:0] i_tag,
    input  logic [WCNT_W-1:0]          i_ways,
    output sacl_pkg::t_outcome         o_outcome
);
    import sacl_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef t_line [MAX_WAYS-1:0] t_row;

    t_row              r_mem [MAX_SETS];
    logic [MAX_SETS-1:0] r_ok;
    t_row              r_q;
    logic              r_q_ok;
    t_row              row_v;
    t_row              new_row;
    t_row              aged_row;
    t_row              wr_row;
    logic              wr_en;
    logic              hit_f;
    logic              inv_f;
    logic [WAY_W-1:0]  hit_w;
    logic [WAY_W-1:0]  inv_w;
    logic [WAY_W-1:0]  vic_w;
    logic [AGE_W-1:0]  best;

    // A row never written reads as all lines invalid.
    assign row_v = r_q_ok ? r_q : '0;

    always_comb begin
        hit_f     = 1'b0;
        inv_f     = 1'b0;
        hit_w     = '0;
        inv_w     = '0;
        vic_w     = '0;
        best      = row_v[0].age;
        new_row   = row_v;
        o_outcome = OUT_HIT;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WCNT_W'(w) < i_ways) begin
                if (row_v[w].valid && row_v[w].tag == i_tag && !hit_f) begin
                    hit_f = 1'b1;
                    hit_w = WAY_W'(w);
                end
                if (!row_v[w].valid && !inv_f) begin
                    inv_f = 1'b1;
                    inv_w = WAY_W'(w);
                end
                if (w > 0 && row_v[w].age > best) begin
                    best  = row_v[w].age;
                    vic_w = WAY_W'(w);
                end
            end
        end
        if (hit_f) begin
            new_row[hit_w].age = '0;
            o_outcome          = OUT_HIT;
        end else if (inv_f) begin
            new_row[inv_w].valid = 1'b1;
            new_row[inv_w].tag   = i_tag;
            new_row[inv_w].age   = '0;
            o_outcome            = OUT_MISS;
        end else begin
            new_row[vic_w].tag = i_tag;
            new_row[vic_w].age = '0;
            o_outcome          = OUT_EVICT;
        end
    end

    always_comb begin
        aged_row = row_v;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WCNT_W'(w) < i_ways && row_v[w].valid && row_v[w].age != '1) begin
                aged_row[w].age = row_v[w].age + AGE_W'(1);
            end
        end
    end

    assign wr_en  = i_ctl.lookup_wr | i_ctl.age_wr;
    assign wr_row = i_ctl.lookup_wr ? new_row : aged_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_wr_set] <= wr_row;
        end
        if (i_ctl.rd) begin
            r_q <= r_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok   <= '0;
            r_q_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_ok[i_wr_set] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_q_ok <= r_ok[i_rd_set];
            end
        end
    end
endmodule

// ===== rtl/sacl_2q.sv =====
module sacl_2q #(
    parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
    parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sacl_pkg::t_unit_ctl        i_ctl,
    input  logic [SET_W-1:0]           i_set,
    input  logic [sacl_pkg::TAG_W-1:0] i_tag,
    input  logic [WCNT_W-1:0]          i_ways,
    output sacl_pkg::t_outcome         o_outcome
);
    import sacl_pkg::*;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0] t_queue;

    typedef struct packed {
        logic [WCNT_W-1:0] pfill;
        logic [WCNT_W-1:0] mfill;
        t_queue            pq;
        t_queue            mq;
    } t_qrow;

    t_qrow               r_mem [MAX_SETS];
    logic [MAX_SETS-1:0] r_ok;
    t_qrow               r_q;
    logic                r_q_ok;
    t_qrow               row_v;
    t_qrow               new_row;
    t_queue              mq_sh;
    t_queue              pq_sh;
    logic [WCNT_W-1:0]   mf;
    logic [WCNT_W-1:0]   pf;
    logic [WCNT_W-1:0]   jf;
    logic [WCNT_W-1:0]   mi;
    logic [WCNT_W-1:0]   pi;
    logic                mhit;
    logic                phit;

    // A row never written holds empty queues.
    assign row_v = r_q_ok ? r_q : '0;
    assign mf    = row_v.mfill;
    assign pf    = row_v.pfill;
    assign mq_sh = row_v.mq >> TAG_W;
    assign pq_sh = row_v.pq >> TAG_W;

    always_comb begin
        mhit = 1'b0;
        phit = 1'b0;
        mi   = '0;
        pi   = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WCNT_W'(j) < mf && row_v.mq[j] == i_tag && !mhit) begin
                mhit = 1'b1;
                mi   = WCNT_W'(j);
            end
            if (WCNT_W'(j) < pf && row_v.pq[j] == i_tag && !phit) begin
                phit = 1'b1;
                pi   = WCNT_W'(j);
            end
        end
    end

    always_comb begin
        new_row   = row_v;
        o_outcome = OUT_MISS;
        jf        = '0;
        if (mhit) begin
            // Hit in main: the tag moves to the tail.
            o_outcome = OUT_HIT;
            for (int j = 0; j < MAX_WAYS; j++) begin
                jf = WCNT_W'(j);
                if (jf >= mi && jf + WCNT_W'(1) < mf) begin
                    new_row.mq[j] = mq_sh[j];
                end
                if (jf + WCNT_W'(1) == mf) begin
                    new_row.mq[j] = i_tag;
                end
            end
        end else if (phit) begin
            // Hit in probation: promoted to main, still counted as a miss.
            new_row.pfill = pf - WCNT_W'(1);
            for (int j = 0; j < MAX_WAYS; j++) begin
                jf = WCNT_W'(j);
                if (jf >= pi && jf + WCNT_W'(1) < pf) begin
                    new_row.pq[j] = pq_sh[j];
                end
            end
            if (mf >= i_ways) begin
                o_outcome = OUT_EVICT;
                for (int j = 0; j < MAX_WAYS; j++) begin
                    jf = WCNT_W'(j);
                    if (jf + WCNT_W'(1) < mf) begin
                        new_row.mq[j] = mq_sh[j];
                    end
                    if (jf + WCNT_W'(1) == mf) begin
                        new_row.mq[j] = i_tag;
                    end
                end
            end else begin
                new_row.mfill = mf + WCNT_W'(1);
                for (int j = 0; j < MAX_WAYS; j++) begin
                    if (WCNT_W'(j) == mf) begin
                        new_row.mq[j] = i_tag;
                    end
                end
            end
        end else if (pf < i_ways) begin
            new_row.pfill = pf + WCNT_W'(1);
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (WCNT_W'(j) == pf) begin
                    new_row.pq[j] = i_tag;
                end
            end
        end else begin
            // Probation full: its head is dropped without an eviction.
            for (int j = 0; j < MAX_WAYS; j++) begin
                jf = WCNT_W'(j);
                if (jf + WCNT_W'(1) < pf) begin
                    new_row.pq[j] = pq_sh[j];
                end
                if (jf + WCNT_W'(1) == pf) begin
                    new_row.pq[j] = i_tag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup_wr) begin
            r_mem[i_set] <= new_row;
        end
        if (i_ctl.rd) begin
            r_q <= r_mem[i_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok   <= '0;
            r_q_ok <= 1'b0;
        end else begin
            if (i_ctl.lookup_wr) begin
                r_ok[i_set] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_q_ok <= r_ok[i_set];
            end
        end
    end
endmodule

// ===== rtl/set_assoc_cache_lookup_lru_2q_unit.sv =====
// Set-associative cache lookup classifier with LRU or two-queue replacement.
// Input transactions on i_in carry an access mode and a byte address; each
// load or store yields one result transaction on o_out, a modify yields two
// (is_last marks the final one) and an ignored access yields none. Each
// result carries the outcome and the running hit, miss and eviction totals.
// The configuration channel i_cfg writes policy, block size, set count and
// ways; it is always ready and is meant to be written while the block idles.
// A load, store or modify runs through the shared serial divider, which splits
// the address by block size, then the block by set count, one bit a cycle each.
// Each lookup is a read and a write-back of one set row in the line or queue
// memory, and the aging pass then sweeps every active set row of the line
// memory, one row per cycle with read and write overlapped.
// A new access is taken only when the previous one is fully done, but a
// finished result may still sit in the output register meanwhile. When the
// receiver stalls, the block holds before writing back its next lookup.
// Reset restores the default configuration, zeroes the totals and clears the
// per-row valid bits, so no clearing pass over the memories is needed.
module set_assoc_cache_lookup_lru_2q_unit #(
    parameter int MAX_SETS     = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacl_in_if.sink     i_in,
    sacl_cfg_if.sink    i_cfg,
    sacl_out_if.source  o_out
);
    import sacl_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SCNT_W = $clog2(MAX_SETS + 1);
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int DEN_W  = (SCNT_W > BB_W) ? SCNT_W : BB_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_RD   = 6'b001000,
        S_EVAL = 6'b010000,
        S_AGE  = 6'b100000
    } t_state;

    t_state              r_state;
    logic                r_policy;
    logic [BB_W-1:0]     r_block_bytes;
    logic [SCFG_W-1:0]   r_set_count;
    logic [WCFG_W-1:0]   r_ways;
    logic                r_second;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_W-1:0]    r_set;
    logic [SCNT_W-1:0]   r_sw_rd;
    logic                r_sw_pend;
    logic [SET_W-1:0]    r_sw_wset;
    logic                r_out_v;
    t_outcome            r_outcome;
    logic                r_last;
    logic [TOTAL_W-1:0]  r_hits;
    logic [TOTAL_W-1:0]  r_misses;
    logic [TOTAL_W-1:0]  r_evicts;

    logic [BB_W-1:0]         bb_eff;
    logic [SCNT_W-1:0]       sets_eff;
    logic [WCNT_W-1:0]       ways_eff;
    logic                    in_acc;
    logic                    out_free;
    logic                    div_start;
    logic [ADDRESS_BITS-1:0] div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_busy;
    logic [ADDRESS_BITS-1:0] div_quot;
    logic [DEN_W-1:0]        div_rem;
    logic                    sw_issue;
    logic                    eval_go;
    t_unit_ctl               lru_ctl;
    t_unit_ctl               q_ctl;
    logic [SET_W-1:0]        lru_rd_set;
    logic [SET_W-1:0]        lru_wr_set;
    t_outcome                lru_outcome;
    t_outcome                q_outcome;
    t_outcome                outcome;

    // Out-of-range settings behave as the nearest legal value.
    assign bb_eff = (r_block_bytes == '0) ? BB_W'(1) : r_block_bytes;

    always_comb begin
        if (r_set_count == '0) begin
            sets_eff = SCNT_W'(1);
        end else if (32'(r_set_count) > 32'(MAX_SETS)) begin
            sets_eff = SCNT_W'(MAX_SETS);
        end else begin
            sets_eff = SCNT_W'(r_set_count);
        end
        if (r_ways == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (32'(r_ways) > 32'(MAX_WAYS)) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(r_ways);
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= 1'b0;
            r_block_bytes <= BB_W'(1);
            r_set_count   <= SCFG_W'(1);
            r_ways        <= WCFG_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POLICY:      r_policy      <= i_cfg.data[0];
                REG_BLOCK_BYTES: r_block_bytes <= i_cfg.data[BB_W-1:0];
                REG_SET_COUNT:   r_set_count   <= i_cfg.data[SCFG_W-1:0];
                REG_WAYS:        r_ways        <= i_cfg.data[WCFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_v || o_out.ready;

    // The divider first splits off the block number, then set and tag.
    always_comb begin
        div_start = 1'b0;
        div_num   = i_in.address;
        div_den   = DEN_W'(bb_eff);
        if (in_acc && t_mode'(i_in.mode) != MODE_IGNORE) begin
            div_start = 1'b1;
        end else if (r_state == S_DIV1 && !div_busy) begin
            div_start = 1'b1;
            div_num   = div_quot;
            div_den   = DEN_W'(sets_eff);
        end
    end

    sacl_div #(
        .NUM_W (ADDRESS_BITS),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign sw_issue = (r_state == S_AGE) && (r_sw_rd < sets_eff);
    assign eval_go  = (r_state == S_EVAL) && out_free;

    always_comb begin
        lru_ctl.rd        = (r_state == S_RD) || sw_issue;
        lru_ctl.lookup_wr = eval_go && !r_policy;
        lru_ctl.age_wr    = (r_state == S_AGE) && r_sw_pend;
        q_ctl.rd          = (r_state == S_RD);
        q_ctl.lookup_wr   = eval_go && r_policy;
        q_ctl.age_wr      = 1'b0;
    end

    assign lru_rd_set = (r_state == S_AGE) ? r_sw_rd[SET_W-1:0] : r_set;
    assign lru_wr_set = (r_state == S_AGE) ? r_sw_wset : r_set;

    sacl_lru #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .WCNT_W   (WCNT_W)
    ) u_lru (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lru_ctl),
        .i_rd_set  (lru_rd_set),
        .i_wr_set  (lru_wr_set),
        .i_tag     (r_tag),
        .i_ways    (ways_eff),
        .o_outcome (lru_outcome)
    );

    sacl_2q #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .WCNT_W   (WCNT_W)
    ) u_2q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_set     (r_set),
        .i_tag     (r_tag),
        .i_ways    (ways_eff),
        .o_outcome (q_outcome)
    );

    assign outcome = r_policy ? q_outcome : lru_outcome;

    // Sequencer: divide, then one read and write-back per lookup, then aging.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_second  <= 1'b0;
            r_sw_rd   <= '0;
            r_sw_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && t_mode'(i_in.mode) != MODE_IGNORE) begin
                        r_second <= (t_mode'(i_in.mode) == MODE_MODIFY);
                        r_state  <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (!div_busy) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (!div_busy) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (out_free) begin
                        if (r_second) begin
                            r_second <= 1'b0;
                            r_state  <= S_RD;
                        end else begin
                            r_sw_rd   <= '0;
                            r_sw_pend <= 1'b0;
                            r_state   <= S_AGE;
                        end
                    end
                end
                S_AGE: begin
                    r_sw_pend <= sw_issue;
                    if (sw_issue) begin
                        r_sw_rd <= r_sw_rd + SCNT_W'(1);
                    end else if (!r_sw_pend) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV2 && !div_busy) begin
            r_tag <= TAG_W'(div_quot);
            r_set <= div_rem[SET_W-1:0];
        end
        if (sw_issue) begin
            r_sw_wset <= r_sw_rd[SET_W-1:0];
        end
        if (eval_go) begin
            r_outcome <= outcome;
            r_last    <= !r_second;
        end
    end

    // The totals double as the output payload: they change only when a new
    // result is loaded into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            if (eval_go) begin
                r_out_v <= 1'b1;
                if (outcome == OUT_HIT) begin
                    r_hits <= r_hits + TOTAL_W'(1);
                end else begin
                    r_misses <= r_misses + TOTAL_W'(1);
                end
                if (outcome == OUT_EVICT) begin
                    r_evicts <= r_evicts + TOTAL_W'(1);
                end
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_v;
    assign o_out.outcome         = r_outcome;
    assign o_out.is_last         = r_last;
    assign o_out.total_hits      = r_hits;
    assign o_out.total_misses    = r_misses;
    assign o_out.total_evictions = r_evicts;
endmodule
